FILE: design/assert_macros.svh
// Assertion macros shared by the tokenizer RTL.
// Needs signals named clock and reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Expression that must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

FILE: design/csvft_pkg.sv
// Package for the CSV field tokenizer: types, codes and constants.
// No dependencies; used by csvft_core and csv_field_tokenizer.
package csvft_pkg;

   localparam int DEF_MAX_ROWS = 1024;
   localparam int DEF_MAX_COLS = 64;

   localparam int ROW_W  = 10;
   localparam int COL_W  = 6;
   localparam int CHAR_W = 8;
   localparam int SLOTS  = 3;

   localparam logic [CHAR_W-1:0] CH_QUOTE   = 8'h22;
   localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

   typedef enum logic [1:0] {
      MODE_START      = 2'd0,
      MODE_UNQUOTED   = 2'd1,
      MODE_QUOTED     = 2'd2,
      MODE_QUOTE_SEEN = 2'd3
   } mode_type;

   typedef enum logic {
      KIND_CHAR      = 1'b0,
      KIND_FIELD_END = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  column;
      logic [CHAR_W-1:0] char_out;
   } result_type;

   // Results caused by one byte, slot 0 first.
   typedef struct packed {
      logic [1:0]             cnt;
      result_type [SLOTS-1:0] slot;
   } step_out_type;

endpackage

FILE: design/csvft_core.sv
// Tokenizer state (mode, row, column, field flag) and per-byte step logic.
// Depends on csvft_pkg.
module csvft_core #(
   parameter int MAX_ROWS = csvft_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = csvft_pkg::DEF_MAX_COLS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [csvft_pkg::CHAR_W-1:0]  data_byte,
   input  logic                          end_of_file,
   output csvft_pkg::step_out_type       step_out
);

   localparam int RW = $clog2(MAX_ROWS + 1);
   localparam int CW = $clog2(MAX_COLS + 1);
   localparam logic [RW-1:0] ROW_LIMIT = RW'(MAX_ROWS);
   localparam logic [CW-1:0] COL_LIMIT = CW'(MAX_COLS);

   csvft_pkg::mode_type mode_ff, mode_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [CW-1:0]       col_ff, col_in;
   logic                nonempty_ff, nonempty_in;

   function automatic logic [csvft_pkg::ROW_W-1:0] row_field(input logic [RW-1:0] v);
      logic [RW+csvft_pkg::ROW_W-1:0] ext;
      ext = {{csvft_pkg::ROW_W{1'b0}}, v};
      return ext[csvft_pkg::ROW_W-1:0];
   endfunction

   function automatic logic [csvft_pkg::COL_W-1:0] col_field(input logic [CW-1:0] v);
      logic [CW+csvft_pkg::COL_W-1:0] ext;
      ext = {{csvft_pkg::COL_W{1'b0}}, v};
      return ext[csvft_pkg::COL_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= csvft_pkg::MODE_START;
         row_ff      <= '0;
         col_ff      <= '0;
         nonempty_ff <= 1'b0;
      end else if (advance) begin
         mode_ff     <= mode_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         nonempty_ff <= nonempty_in;
      end
   end

   always_comb begin
      csvft_pkg::mode_type m_hd;
      logic                is_nl, is_q, is_comma, in_range;
      logic                do_a, do_b, do_c;
      logic [RW-1:0]       r;
      logic [CW-1:0]       c;
      logic                nz;
      logic [1:0]          n;

      is_nl    = (data_byte == csvft_pkg::CH_NEWLINE);
      is_q     = (data_byte == csvft_pkg::CH_QUOTE);
      is_comma = (data_byte == csvft_pkg::CH_COMMA);
      in_range = (row_ff < ROW_LIMIT) && (col_ff < COL_LIMIT);
      do_a     = 1'b0;
      do_b     = 1'b0;
      do_c     = 1'b0;
      m_hd     = mode_ff;

      if (!in_range || is_nl) begin
         do_c = is_nl;
      end else begin
         case (mode_ff)
            csvft_pkg::MODE_START: begin
               if (is_q) begin
                  m_hd = csvft_pkg::MODE_QUOTED;
               end else if (is_comma) begin
                  do_a = 1'b1;
                  m_hd = csvft_pkg::MODE_START;
               end else begin
                  do_b = 1'b1;
                  m_hd = csvft_pkg::MODE_UNQUOTED;
               end
            end
            csvft_pkg::MODE_UNQUOTED: begin
               if (is_comma) begin
                  do_a = 1'b1;
                  m_hd = csvft_pkg::MODE_START;
               end else begin
                  do_b = 1'b1;
               end
            end
            csvft_pkg::MODE_QUOTED: begin
               if (is_q) m_hd = csvft_pkg::MODE_QUOTE_SEEN;
               else      do_b = 1'b1;
            end
            csvft_pkg::MODE_QUOTE_SEEN: begin
               if (is_q) begin
                  // doubled quote: literal quote, stay quoted
                  do_b = 1'b1;
                  m_hd = csvft_pkg::MODE_QUOTED;
               end else if (is_comma) begin
                  do_a = 1'b1;
                  m_hd = csvft_pkg::MODE_START;
               end else begin
                  // stray byte after closing quote opens a new unquoted field
                  do_a = 1'b1;
                  do_b = ((col_ff + CW'(1)) < COL_LIMIT);
                  m_hd = do_b ? csvft_pkg::MODE_UNQUOTED : csvft_pkg::MODE_START;
               end
            end
            default: m_hd = csvft_pkg::MODE_START;
         endcase
      end

      // final byte closes the open line unless it was a newline already
      if (end_of_file && !is_nl) do_c = 1'b1;

      r        = row_ff;
      c        = col_ff;
      nz       = nonempty_ff;
      n        = '0;
      step_out = '0;

      if (do_a) begin
         if (nz) begin
            step_out.slot[n].kind   = csvft_pkg::KIND_FIELD_END;
            step_out.slot[n].row    = row_field(r);
            step_out.slot[n].column = col_field(c);
            n = n + 2'd1;
         end
         nz = 1'b0;
         if (c < COL_LIMIT) c = c + CW'(1);
      end
      if (do_b) begin
         step_out.slot[n].kind     = csvft_pkg::KIND_CHAR;
         step_out.slot[n].row      = row_field(r);
         step_out.slot[n].column   = col_field(c);
         step_out.slot[n].char_out = data_byte;
         n  = n + 2'd1;
         nz = 1'b1;
      end
      if (do_c) begin
         if (nz) begin
            step_out.slot[n].kind   = csvft_pkg::KIND_FIELD_END;
            step_out.slot[n].row    = row_field(r);
            step_out.slot[n].column = col_field(c);
            n = n + 2'd1;
         end
         nz = 1'b0;
         if (r < ROW_LIMIT) r = r + RW'(1);
         c = '0;
      end
      step_out.cnt = n;

      mode_in     = do_c ? csvft_pkg::MODE_START : m_hd;
      row_in      = r;
      col_in      = c;
      nonempty_in = nz;
      if (end_of_file) begin
         mode_in     = csvft_pkg::MODE_START;
         row_in      = '0;
         col_in      = '0;
         nonempty_in = 1'b0;
      end
   end

endmodule

FILE: design/csv_field_tokenizer.sv
// CSV field tokenizer top level: input register, result buffer and drain.
// Depends on csvft_pkg, csvft_core and assert_macros.svh.
//
// Takes one CSV byte per transaction on the req_ channel and returns the
// field characters and field-end markers on the rsp_ channel, each tagged
// with row and column; rsp_last marks the final result of a byte. Quoted
// fields follow the usual CSV rules (doubled quote is a literal quote);
// columns at or past MAX_COLS and rows at or past MAX_ROWS give no results.
// Rate: a byte is accepted every cycle as long as each byte yields at most
// one result and rsp_stall is low. A byte yielding k results (k up to 3)
// holds the 3-entry result buffer until all k are drained, and the next
// byte with results waits for that; bytes yielding no result update state
// without using the buffer. An accepted byte passes through the input
// register, then the result buffer. The result buffer is drained one entry
// per rsp_ transaction; a new byte is loaded in the same cycle its last
// entry leaves, so no bubbles. No clearing pass: ready right after reset.
`include "assert_macros.svh"

module csv_field_tokenizer #(
   parameter int MAX_ROWS = csvft_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = csvft_pkg::DEF_MAX_COLS
) (
   input  logic                          clock,
   input  logic                          reset,
   // byte input
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [csvft_pkg::CHAR_W-1:0]  req_data_byte,
   input  logic                          req_end_of_file,
   // token output
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_kind,
   output logic [csvft_pkg::ROW_W-1:0]   rsp_row,
   output logic [csvft_pkg::COL_W-1:0]   rsp_column,
   output logic [csvft_pkg::CHAR_W-1:0]  rsp_char_out,
   output logic                          rsp_last
);

   // Input register
   logic                         in_valid_ff, in_valid_in;
   logic [csvft_pkg::CHAR_W-1:0] in_byte_ff;
   logic                         in_eof_ff;

   // Result buffer
   csvft_pkg::result_type [csvft_pkg::SLOTS-1:0] buf_ff;
   logic [1:0]                   cnt_ff, cnt_in;
   logic [1:0]                   idx_ff, idx_in;
   logic                         buf_valid_ff, buf_valid_in;

   csvft_pkg::step_out_type      step_out;
   csvft_pkg::result_type        cur;
   logic                         advance, load, pop, last_slot, buf_free;

   csvft_core #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .data_byte   (in_byte_ff),
      .end_of_file (in_eof_ff),
      .step_out    (step_out)
   );

   // Drain side
   assign cur       = buf_ff[idx_ff];
   assign pop       = buf_valid_ff && !rsp_stall;
   assign last_slot = (idx_ff == (cnt_ff - 2'd1));
   assign buf_free  = !buf_valid_ff || (pop && last_slot);

   // A byte with no results updates state without touching the buffer.
   assign advance   = in_valid_ff && ((step_out.cnt == 2'd0) || buf_free);
   assign load      = advance && (step_out.cnt != 2'd0);
   assign req_stall = in_valid_ff && !advance;

   assign rsp_valid    = buf_valid_ff;
   assign rsp_kind     = cur.kind;
   assign rsp_row      = cur.row;
   assign rsp_column   = cur.column;
   assign rsp_char_out = cur.char_out;
   assign rsp_last     = last_slot;

   always_comb begin
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      buf_valid_in = buf_valid_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      if (load) begin
         buf_valid_in = 1'b1;
         cnt_in       = step_out.cnt;
         idx_in       = '0;
      end else if (pop) begin
         if (last_slot) buf_valid_in = 1'b0;
         else           idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         buf_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         buf_valid_ff <= buf_valid_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
         in_eof_ff  <= req_end_of_file;
      end
      if (load) buf_ff <= step_out.slot;
   end

   // Checks
   `ASSERT_CLK(a_idx_in_range, buf_valid_ff |-> (idx_ff < cnt_ff), "buffer index past count")
   `ASSERT_CLK(a_no_gap_in_burst, (pop && !last_slot) |=> rsp_valid, "results of a byte split")
   `ASSERT_NEVER(a_end_char_zero, rsp_valid && (rsp_kind == csvft_pkg::KIND_FIELD_END) && (rsp_char_out != '0), "field end carries a char")
   `ASSERT_NEVER(a_load_overrun, load && !buf_free, "buffer overwritten")

endmodule
